>>> rtl/core/bps_pkg.sv
package bps_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAC_BITS  = 8;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int SIZE_W  = 9;
    localparam int COORD_W = 17;
    localparam int PIX_W   = 24;
    localparam int OUT_W   = 32;
    localparam int IN_W    = 80;
    localparam int WT_W    = 2 * (FRAC_BITS + 1) - 1;
    localparam int PROD_W  = PIX_W;
    localparam int BANK_AW = (COL_W - 1) + (ROW_W - 1);
    localparam int BANK_D  = 1 << BANK_AW;

    localparam logic [SIZE_W-1:0] ONE_UNIT = SIZE_W'(1 << FRAC_BITS);

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } t_reg_index;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [COL_W-1:0]  lo;
        logic [SIZE_W-1:0] w_hi;
    } t_axis;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        if (v < SIZE_W'(2)) r = SIZE_W'(2);
        else if (v > maxv)  r = maxv;
        else                r = v;
        return r;
    endfunction

    // negative clamps to 0; past the last pair, the upper neighbour takes full weight
    function automatic t_axis axis_setup(input logic [COORD_W-1:0] raw,
                                         input logic [SIZE_W-1:0]  size);
        t_axis             a;
        logic [COL_W-1:0]  ipart;
        logic [SIZE_W-1:0] ip1;
        logic [SIZE_W-1:0] lo_edge;
        ipart   = raw[COORD_W-1] ? '0 : raw[FRAC_BITS +: COL_W];
        ip1     = {1'b0, ipart} + SIZE_W'(1);
        lo_edge = size - SIZE_W'(2);
        if (ip1 >= size) begin
            a.lo   = lo_edge[COL_W-1:0];
            a.w_hi = ONE_UNIT;
        end else begin
            a.lo   = ipart;
            a.w_hi = raw[COORD_W-1] ? '0 : {1'b0, raw[FRAC_BITS-1:0]};
        end
        return a;
    endfunction

endpackage

>>> rtl/core/bilinear_pixel_sampler.sv
// Bilinear sampler over a 256x256 frame of 24-bit BGR pixels. Each input word is either a
// pixel write (tuser 0) or a sample request (tuser 1); writes give no output word, samples
// give one 32-bit colour with alpha 255. One word is taken every cycle while the output is not
// stalled, and a sample's result passes through four register stages: axis setup,
// store read with weight products, channel products, then sum, round and output register.
// The frame store is four banks of 16384 x 24 split by column and row parity, so the four
// neighbours of a sample are read in the same cycle, one word per bank. The store is not
// cleared by reset; sampling a pixel never written gives an undefined colour. Sizes must
// be set over the cfg port only while the block is idle; the block does not enforce this.
module bilinear_pixel_sampler (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // write_x 7:0, write_y 15:8, write_colour 39:16, sample_x 56:40, sample_y 73:57, zero 79:74
    input  logic [bps_pkg::IN_W-1:0]     i_s_tdata,
    // opcode
    input  logic                         i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // sampled_colour 31:0
    output logic [bps_pkg::OUT_W-1:0]    o_m_tdata,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [bps_pkg::SIZE_W-1:0]   i_cfg_data
);
    import bps_pkg::*;

    localparam int HA = COL_W - 1;
    localparam int VA = ROW_W - 1;

    logic [SIZE_W-1:0] r_width, r_height;

    logic en1, en2, en3, en4;

    // stage 1
    logic               r1_v, r1_sample;
    logic [COL_W-1:0]   r1_xlo;
    logic [ROW_W-1:0]   r1_ylo;
    logic [SIZE_W-1:0]  r1_wx, r1_wy;
    logic [HA-1:0]      r1_xa [2];
    logic [VA-1:0]      r1_ya [2];
    logic [1:0]         r1_wbank;
    logic [BANK_AW-1:0] r1_waddr;
    logic [PIX_W-1:0]   r1_wdata;

    // stage 2
    logic               r2_v;
    logic [1:0]         r2_par;
    logic [WT_W-1:0]    r2_wt [4];
    logic [PIX_W-1:0]   r_bank_q [4];

    // stage 3
    logic               r3_v;
    logic [PROD_W-1:0]  r3_prod [3][4];

    // output
    logic               r_out_v;
    logic [OUT_W-1:0]   r_out;

    t_axis              n_ax, n_ay;
    logic [COL_W-1:0]   n_wx;
    logic [ROW_W-1:0]   n_wy;
    logic [SIZE_W-1:0]  n_wx1, n_wy1;
    logic [PROD_W-1:0]  n_prod [3][4];
    logic [7:0]         n_chan [3];

    assign o_cfg_ready = 1'b1;
    assign en4 = !r_out_v || i_m_tready;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign o_s_tready = en1;
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_W'(MAX_WIDTH);
            r_height <= SIZE_W'(MAX_HEIGHT);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_width  <= clamp_size(i_cfg_data, SIZE_W'(MAX_WIDTH));
                REG_FRAME_HEIGHT: r_height <= clamp_size(i_cfg_data, SIZE_W'(MAX_HEIGHT));
                default: ;
            endcase
        end
    end

    // stage 1: axis setup and bank addresses
    assign n_ax = axis_setup(i_s_tdata[56:40], r_width);
    assign n_ay = axis_setup(i_s_tdata[73:57], r_height);
    assign n_wx = i_s_tdata[7:0];
    assign n_wy = i_s_tdata[15:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_sample <= (i_s_tuser == OP_SAMPLE);
            r1_xlo    <= n_ax.lo;
            r1_ylo    <= n_ay.lo[ROW_W-1:0];
            r1_wx     <= n_ax.w_hi;
            r1_wy     <= n_ay.w_hi;
            // even parity bank takes the next pair up when the low neighbour is odd
            r1_xa[0]  <= n_ax.lo[COL_W-1:1] + HA'(n_ax.lo[0]);
            r1_xa[1]  <= n_ax.lo[COL_W-1:1];
            r1_ya[0]  <= n_ay.lo[ROW_W-1:1] + VA'(n_ay.lo[0]);
            r1_ya[1]  <= n_ay.lo[ROW_W-1:1];
            r1_wbank  <= {n_wy[0], n_wx[0]};
            r1_waddr  <= {n_wy[ROW_W-1:1], n_wx[COL_W-1:1]};
            r1_wdata  <= i_s_tdata[39:16];
        end
    end

    // stage 2: banked store and weight products
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [PIX_W-1:0]   mem [BANK_D];
        logic               we, re;
        logic [BANK_AW-1:0] raddr;

        assign we    = en2 && r1_v && !r1_sample && (r1_wbank == 2'(b));
        assign re    = en2 && r1_v && r1_sample;
        assign raddr = {r1_ya[b/2], r1_xa[b%2]};

        always_ff @(posedge i_clk) begin
            if (we) begin
                mem[r1_waddr] <= r1_wdata;
            end
            if (re) begin
                r_bank_q[b] <= mem[raddr];
            end
        end
    end

    assign n_wx1 = ONE_UNIT - r1_wx;
    assign n_wy1 = ONE_UNIT - r1_wy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= r1_v && r1_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_par   <= {r1_ylo[0], r1_xlo[0]};
            r2_wt[0] <= {8'd0, n_wx1} * {8'd0, n_wy1};
            r2_wt[1] <= {8'd0, r1_wx} * {8'd0, n_wy1};
            r2_wt[2] <= {8'd0, n_wx1} * {8'd0, r1_wy};
            r2_wt[3] <= {8'd0, r1_wx} * {8'd0, r1_wy};
        end
    end

    // stage 3: channel products, neighbour n lives in bank n xor parity
    always_comb begin
        for (int n = 0; n < 4; n++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[c][n] = {7'd0, r2_wt[n]}
                             * {16'd0, r_bank_q[2'(n) ^ r2_par][8*c +: 8]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en3) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_prod <= n_prod;
        end
    end

    // stage 4: sum, round, output word
    always_comb begin
        logic [PROD_W+1:0] acc;
        for (int c = 0; c < 3; c++) begin
            acc = (PROD_W+2)'(128 * 256)
                + {2'd0, r3_prod[c][0]} + {2'd0, r3_prod[c][1]}
                + {2'd0, r3_prod[c][2]} + {2'd0, r3_prod[c][3]};
            n_chan[c] = acc[23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en4) begin
            r_out_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_out <= {8'd255, n_chan[2], n_chan[1], n_chan[0]};
        end
    end

    a_lo_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_v && r1_sample |-> ({1'b0, r1_xlo} + SIZE_W'(1) < r_width)
                           && ({1'b0, r1_ylo} + SIZE_W'(1) < r_height))
        else $error("low neighbour outside frame in use");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_v && r1_sample |-> (r1_wx <= ONE_UNIT) && (r1_wy <= ONE_UNIT))
        else $error("axis weight above one");

    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_v |-> ({2'd0, r2_wt[0]} + {2'd0, r2_wt[1]} + {2'd0, r2_wt[2]}
                  + {2'd0, r2_wt[3]}) == (WT_W+2)'(256 * 256))
        else $error("neighbour weights do not sum to one");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !i_m_tready |=> r_out_v && $stable(r_out))
        else $error("stalled output word changed");

    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> r_out[31:24] == 8'd255)
        else $error("alpha not opaque");

endmodule
